[rtl/core/insertion_sorter_macros.svh]
// Assertion macros used by the checker file.
`ifndef INSERTION_SORTER_MACROS_SVH
`define INSERTION_SORTER_MACROS_SVH

// Same-cycle implication, sampled on the rising clock, muted in reset.
`define ISORT_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on the rising clock, muted in reset.
`define ISORT_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[rtl/core/isort_pkg.sv]
`timescale 1ns / 1ps

package isort_pkg;

   localparam int DATA_W        = 32;
   localparam int DEPTH_DEFAULT = 16;

   // Per-cycle command to every cell of the chain.
   typedef struct packed {
      logic insert;   // place the accepted word
      logic shift;    // move the list one cell toward the head
   } cell_ctl_type;

   // What a cell shows its neighbors.
   typedef struct packed {
      logic              valid;
      logic              gt;     // held word is greater than the incoming word
      logic [DATA_W-1:0] data;
   } link_type;

endpackage

[rtl/core/isort_if.sv]
`timescale 1ns / 1ps

interface isort_req_if;
   logic                               valid;
   logic                               ready;
   logic signed [isort_pkg::DATA_W-1:0] value;
   logic                               last;

   modport source (output valid, output value, output last, input ready);
   modport sink   (input valid, input value, input last, output ready);
endinterface

interface isort_rsp_if;
   logic                               valid;
   logic                               ready;
   logic signed [isort_pkg::DATA_W-1:0] sorted_value;
   logic                               end_of_set;
   logic                               overflow;

   modport source (output valid, output sorted_value, output end_of_set,
                   output overflow, input ready);
   modport sink   (input valid, input sorted_value, input end_of_set,
                   input overflow, output ready);
endinterface

[rtl/core/isort_cell.sv]
`timescale 1ns / 1ps

module isort_cell (
   input  logic                          clock,
   input  logic                          reset,
   input  isort_pkg::cell_ctl_type       ctl,
   input  logic [isort_pkg::DATA_W-1:0]  value,
   input  isort_pkg::link_type           left,
   input  isort_pkg::link_type           right,
   output isort_pkg::link_type           self_link
);

   logic                         valid_ff, valid_in;
   logic [isort_pkg::DATA_W-1:0] data_ff, data_in;
   logic                         gt;
   logic                         take;

   // strictly greater: equal words stay ahead of the new one
   assign gt   = valid_ff && ($signed(data_ff) > $signed(value));
   assign take = gt || (!valid_ff && left.valid);

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      if (ctl.shift) begin
         valid_in = right.valid;
         data_in  = right.data;
      end else if (ctl.insert && take) begin
         valid_in = 1'b1;
         // left neighbor moves over if it is also greater, else the new word lands here
         data_in  = left.gt ? left.data : value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign self_link.valid = valid_ff;
   assign self_link.gt    = gt;
   assign self_link.data  = data_ff;

endmodule

[rtl/core/insertion_sorter.sv]
`timescale 1ns / 1ps
// Fill: one word accepted per cycle; the compare-and-hold chain places it in that cycle.
// Drain: starts the cycle after the last word; one sorted word per cycle from the head cell
//   while the receiver is ready, with no input taken until the set has left.
// Overflow words (beyond DEPTH) are dropped as they arrive and do not stall the input.
// Reset (synchronous, active high) empties the chain and clears drain and overflow state.
module insertion_sorter #(
   parameter int DEPTH = isort_pkg::DEPTH_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   isort_req_if.sink   req_chan,
   isort_rsp_if.source rsp_chan
);

   isort_pkg::link_type     lnk [DEPTH];
   isort_pkg::link_type     head_bound;
   isort_pkg::link_type     tail_bound;
   isort_pkg::cell_ctl_type ctl;

   logic drain_ff, drain_in;
   logic dropped_ff, dropped_in;
   logic full;
   logic req_acc;
   logic rsp_acc;
   logic rsp_end;

   // cell 0 always has room on its left; nothing arrives from beyond the tail
   assign head_bound.valid = 1'b1;
   assign head_bound.gt    = 1'b0;
   assign head_bound.data  = '0;
   assign tail_bound.valid = 1'b0;
   assign tail_bound.gt    = 1'b0;
   assign tail_bound.data  = '0;

   assign full    = lnk[DEPTH-1].valid;
   assign req_acc = req_chan.valid && req_chan.ready;
   assign rsp_end = !lnk[1].valid;
   assign rsp_acc = rsp_chan.valid && rsp_chan.ready;

   assign ctl.insert = req_acc && !full;
   assign ctl.shift  = rsp_acc;

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      isort_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .ctl       (ctl),
         .value     (req_chan.value),
         .left      ((i == 0) ? head_bound : lnk[(i == 0) ? 0 : i-1]),
         .right     ((i == DEPTH-1) ? tail_bound : lnk[(i == DEPTH-1) ? i : i+1]),
         .self_link (lnk[i])
      );
   end

   always_comb begin
      drain_in   = drain_ff;
      dropped_in = dropped_ff;
      priority if (rsp_acc && rsp_end) begin
         drain_in   = 1'b0;
         dropped_in = 1'b0;
      end else if (req_acc) begin
         if (req_chan.last) begin
            drain_in = 1'b1;
         end
         if (full) begin
            dropped_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         drain_ff   <= 1'b0;
         dropped_ff <= 1'b0;
      end else begin
         drain_ff   <= drain_in;
         dropped_ff <= dropped_in;
      end
   end

   assign req_chan.ready        = !drain_ff;
   assign rsp_chan.valid        = drain_ff && lnk[0].valid;
   assign rsp_chan.sorted_value = $signed(lnk[0].data);
   assign rsp_chan.end_of_set   = rsp_end;
   assign rsp_chan.overflow     = dropped_ff;

endmodule

[rtl/core/isort_checker.sv]
`timescale 1ns / 1ps
`include "insertion_sorter_macros.svh"

module isort_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_valid,
   input logic                                req_ready,
   input logic                                req_last,
   input logic                                rsp_valid,
   input logic                                rsp_ready,
   input logic signed [isort_pkg::DATA_W-1:0] rsp_sorted_value,
   input logic                                rsp_end_of_set
);

   logic req_take;
   logic rsp_take;

   assign req_take = req_valid && req_ready;
   assign rsp_take = rsp_valid && rsp_ready;

   `ISORT_ASSERT_NOW(a_no_input_in_drain, rsp_valid, !req_ready, "input taken while draining")
   `ISORT_ASSERT_NEXT(a_last_starts_drain, req_take && req_last, rsp_valid, "no drain after last")
   `ISORT_ASSERT_NEXT(a_ascending, rsp_take && !rsp_end_of_set, rsp_valid && ($past(rsp_sorted_value) <= rsp_sorted_value), "words out of order")
   `ISORT_ASSERT_NEXT(a_idle_after_end, rsp_take && rsp_end_of_set, !rsp_valid, "word after end of set")
   `ISORT_ASSERT_NEXT(a_stall_holds, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_sorted_value), "stalled word changed")

endmodule

bind insertion_sorter isort_checker u_isort_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_chan.valid),
   .req_ready        (req_chan.ready),
   .req_last         (req_chan.last),
   .rsp_valid        (rsp_chan.valid),
   .rsp_ready        (rsp_chan.ready),
   .rsp_sorted_value (rsp_chan.sorted_value),
   .rsp_end_of_set   (rsp_chan.end_of_set)
);
